// File: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg - shared types and codes of the software timer table
// operation and status codes, transaction payload structs, sequencer states
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int TASK_COUNT = 16;
  localparam int TASK_W     = 4;
  localparam int STEP_W     = 16;
  localparam int TIME_W     = 64;
  localparam int PERIOD_W   = 32;

  // operation codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_SETP  = 3'd4;
  localparam logic [2:0] OP_CHECK = 3'd5;
  localparam logic [2:0] OP_POP   = 3'd6;

  // result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_IGNORED  = 2'd2;
  localparam logic [1:0] STS_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]          opcode;
    logic [2:0]          slot_index;
    logic [PERIOD_W-1:0] period_value;
    logic                repeat_mode;
    logic [TASK_W-1:0]   owner_task;
  } stt_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        slot_granted;
    logic [TASK_W-1:0] popped_task;
    logic              pending_valid;
    logic [3:0]        fired_count;
  } stt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADD,
    ST_CHECK,
    ST_POP
  } stt_state_t;

endpackage

// File: rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram - generic single write port ram with registered read
// one write and one read per cycle, contents undefined until written
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table - timer slot table with pending task fifo
// a 64-bit time counter, TIMER_SLOTS timer slots and a fifo of owner task ids,
// worked one operation at a time by a small sequencer over a shared slot port
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload            | notes
//  ---------+----------------------+--------------------+------------------------
//  input    | start / busy         | in_item (stt_in_t) | taken when start & !busy
//  result   | out_valid strobe     | out_item (stt_out_t)| one cycle, no back-pressure
//  config   | cfg_valid / cfg_ready| cfg_data [15:0]    | tick_step register
//
//  steps: tick, start, stop, set period and ignored operations go through the exec
//    state; pop goes through the pop state (fifo ram read is registered); add
//    scans the slots and stops at the first free slot; check always scans all
//    TIMER_SLOTS slots, one slot per cycle through the shared 65-bit expiry adder
//  busy is high from the cycle after accept until the result strobe; a new
//    transaction may be started in the strobe cycle
//  reset: synchronous, active low; counter, step to 1; clears used, start, fifo pointers
//  the receiver cannot stall: every result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module software_timer_table
  import stt_pkg::*;
#(
  parameter int TIMER_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              start,
  output logic              busy,
  input  stt_in_t           in_item,
  // result channel
  output logic              out_valid,
  output stt_out_t          out_item,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STEP_W-1:0] cfg_data
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
  localparam logic [CNT_W-1:0] FIFO_FULL = CNT_W'(TIMER_SLOTS);

  // sequencer and item registers
  stt_state_t          state_r, state_nxt;
  stt_in_t             item_r, item_nxt;
  stt_out_t            res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  // time base and configuration
  logic [TIME_W-1:0]   counter_r, counter_nxt;
  logic [STEP_W-1:0]   tick_step_r;

  // slot table
  logic [TIME_W-1:0]   slot_start_r  [TIMER_SLOTS];
  logic [PERIOD_W-1:0] slot_period_r [TIMER_SLOTS];
  logic [TASK_W-1:0]   slot_owner_r  [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] slot_rep_r;
  logic [TIMER_SLOTS-1:0] slot_used_r;

  // pending fifo pointers
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                fifo_we;
  logic [TASK_W-1:0]   fifo_rd_data;

  // shared slot port
  logic                in_acc;
  logic                scanning;
  logic                scan_last;
  logic                owner_ok;
  logic                slot_in_range;
  logic                slot_ok;
  logic [IDX_W-1:0]    rd_addr;
  logic                used_q;
  logic                rep_q;
  logic [TIME_W-1:0]   start_q;
  logic [PERIOD_W-1:0] period_q;
  logic [TASK_W-1:0]   owner_q;
  logic [TIME_W:0]     expiry_sum;
  logic                hit;

  // slot write strobes
  logic                st_we;
  logic [TIME_W-1:0]   st_wdata;
  logic                per_we;
  logic                add_we;

  assign in_acc    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  // the scan counter owns the slot port during add and check
  assign scanning      = (state_r == ST_ADD) || (state_r == ST_CHECK);
  assign scan_last     = (idx_r == LAST_IDX);
  assign owner_ok      = (32'(in_item.owner_task) < TASK_COUNT);
  assign slot_in_range = (32'(item_r.slot_index) < TIMER_SLOTS);
  assign rd_addr       = scanning ? idx_r : IDX_W'(item_r.slot_index);

  // slot read, guarded so an out-of-range index reads as an unused slot
  assign used_q   = (scanning || slot_in_range) ? slot_used_r[rd_addr] : 1'b0;
  assign rep_q    = slot_rep_r[rd_addr];
  assign start_q  = slot_start_r[rd_addr];
  assign period_q = slot_period_r[rd_addr];
  assign owner_q  = slot_owner_r[rd_addr];
  assign slot_ok  = slot_in_range && used_q;

  // expiry test: a carry out of start + period means not yet expired
  assign expiry_sum = {1'b0, start_q} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, period_q};
  assign hit = used_q && (start_q != '0) && !expiry_sum[TIME_W]
               && (counter_r >= expiry_sum[TIME_W-1:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.opcode)
            OP_ADD:   state_nxt = owner_ok ? ST_ADD : ST_EXEC;
            OP_CHECK: state_nxt = ST_CHECK;
            OP_POP:   state_nxt = ST_POP;
            default:  state_nxt = ST_EXEC;
          endcase
        end
      end
      ST_EXEC, ST_POP: begin
        state_nxt = ST_IDLE;
      end
      ST_ADD: begin
        if (!used_q || scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    item_nxt      = item_r;
    res_nxt       = res_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    counter_nxt   = counter_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    fifo_we       = 1'b0;
    st_we         = 1'b0;
    st_wdata      = '0;
    per_we        = 1'b0;
    add_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt = in_item;
          res_nxt  = '0;
          idx_nxt  = '0;
        end
      end
      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        case (item_r.opcode)
          OP_TICK: begin
            counter_nxt = counter_r + TIME_W'(tick_step_r);
          end
          OP_START: begin
            if (slot_ok) begin
              st_we    = 1'b1;
              st_wdata = counter_r;
            end else begin
              res_nxt.status = STS_IGNORED;
            end
          end
          OP_STOP: begin
            if (slot_ok) begin
              st_we = 1'b1;
            end else begin
              res_nxt.status = STS_IGNORED;
            end
          end
          OP_SETP: begin
            if (slot_ok && (start_q == '0)) begin
              per_we = 1'b1;
            end else begin
              res_nxt.status = STS_IGNORED;
            end
          end
          // add with an unknown owner, and the unused opcode
          default: begin
            res_nxt.status = STS_IGNORED;
          end
        endcase
      end
      ST_ADD: begin
        if (!used_q) begin
          add_we               = 1'b1;
          res_nxt.slot_granted = 3'(idx_r);
          out_valid_nxt        = 1'b1;
        end else if (scan_last) begin
          res_nxt.status = STS_FULL;
          out_valid_nxt  = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_CHECK: begin
        if (hit) begin
          res_nxt.fired_count = res_r.fired_count + 1'b1;
          if (cnt_r < FIFO_FULL) begin
            fifo_we  = 1'b1;
            tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            res_nxt.status = STS_OVERFLOW;
          end
          st_we    = 1'b1;
          st_wdata = rep_q ? counter_r : '0;
        end
        if (scan_last) begin
          out_valid_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_POP: begin
        out_valid_nxt = 1'b1;
        if (cnt_r != '0) begin
          res_nxt.popped_task   = fifo_rd_data;
          res_nxt.pending_valid = 1'b1;
          head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      counter_r   <= TIME_W'(1);
      tick_step_r <= STEP_W'(1);
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      slot_used_r <= '0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        slot_start_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      counter_r   <= counter_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        tick_step_r <= cfg_data;
      end
      if (add_we) begin
        slot_used_r[rd_addr] <= 1'b1;
      end
      if (st_we) begin
        slot_start_r[rd_addr] <= st_wdata;
      end
    end
  end

  // payload registers, written before any use
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    idx_r  <= idx_nxt;
    if (add_we) begin
      slot_owner_r[rd_addr]  <= item_r.owner_task;
      slot_rep_r[rd_addr]    <= item_r.repeat_mode;
      slot_period_r[rd_addr] <= item_r.period_value;
    end else if (per_we) begin
      slot_period_r[rd_addr] <= item_r.period_value;
    end
  end

  // pending task fifo storage, read continuously at the head
  stt_ram #(
    .WIDTH (TASK_W),
    .DEPTH (TIMER_SLOTS)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (tail_r),
    .wr_data (owner_q),
    .rd_addr (head_r),
    .rd_data (fifo_rd_data)
  );

  // fifo occupancy never exceeds its depth
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_FULL)
    else $error("pending fifo count above depth");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result strobe ends a busy period
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a transaction");

  // a popped task only comes with ok status and nothing else set
  a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.pending_valid) |->
      (out_item.status == STS_OK && out_item.fired_count == '0))
    else $error("pop result mixed with other fields");

  // the fifo only grows during a check scan
  a_fifo_push: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_we |-> (state_r == ST_CHECK && hit))
    else $error("fifo write outside a check hit");

endmodule
